// ===== design/mift_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked IP filter table package
// Shared widths, command and status codes, and the per-octet mask builder.
// ----------------------------------------------------------------------------
package mift_pkg;

  localparam int DEPTH    = 1024;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ADDR_W   = 32;
  localparam int ENTRY_W  = 2 * ADDR_W;
  localparam int OUT_W    = 8;

  localparam logic [ADDR_W-1:0] FREE_MARK = 32'hFFFF_FFFF;
  localparam logic [7:0]        OCTET_ALL = 8'hFF;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // A zero octet is a wildcard, any other octet must match exactly.
  function automatic logic [ADDR_W-1:0] build_mask(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (addr[8*k +: 8] != 8'h00) begin
        m[8*k +: 8] = OCTET_ALL;
      end
    end
    return m;
  endfunction

endpackage

// ===== design/masked_ip_filter_table_unit.sv =====
// ----------------------------------------------------------------------------
// Masked IP filter table unit
// A command scans the entries in order, one entry per cycle from the single read
// port of the entry memory, until the first hit or past the last entry; a remove
// that deletes then moves every later entry down one slot. The unused command
// skips the scan. One command is taken at a time: the next is accepted only after
// the result of the last has been raised on the master port.
// Reset empties the table and sets filter_ban to 1; there is no clearing pass.
// ----------------------------------------------------------------------------
module masked_ip_filter_table_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mift_pkg::ADDR_W-1:0]   s_tdata,   // address[31:0]
  input  logic [1:0]                    s_tuser,   // cmd[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mift_pkg::OUT_W-1:0]    m_tdata,   // allowed[0], status[2:1], zero[7:3]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);
  import mift_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT,
    FINISH
  } state_t;

  state_t            state;
  cmd_t              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] mask_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              filter_ban;
  logic              res_allowed;
  status_t           res_status;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [ADDR_W-1:0]  rd_mask;
  logic [ADDR_W-1:0]  rd_cmp;
  logic               hit;
  logic               hit_now;
  logic               in_range;

  assign s_tready  = (state == IDLE) && !rst;
  assign cfg_ready = !rst;

  assign rd_mask  = rd_data[ENTRY_W-1:ADDR_W];
  assign rd_cmp   = rd_data[ADDR_W-1:0];
  assign in_range = (rd_idx < count);
  assign rd_addr  = rd_idx[IDX_W-1:0];

  always_comb begin
    case (cmd_q)
      CMD_CHECK:  hit = ((addr_q & rd_mask) == rd_cmp);
      CMD_ADD:    hit = (rd_cmp == FREE_MARK);
      CMD_REMOVE: hit = (rd_mask == mask_q) && (rd_cmp == addr_q);
      default:    hit = 1'b0;
    endcase
  end

  assign hit_now = (state == SCAN) && pend && hit;

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = pend_idx;
    wr_data = {mask_q, addr_q};
    case (state)
      SCAN: begin
        rd_en = !hit_now && in_range;
        if (cmd_q == CMD_ADD) begin
          if (hit_now) begin
            wr_en = 1'b1;
          end else if (!pend && !in_range && (count != CNT_W'(DEPTH))) begin
            wr_en   = 1'b1;
            wr_addr = count[IDX_W-1:0];
          end
        end
      end
      SHIFT: begin
        rd_en   = in_range;
        wr_en   = pend;
        wr_addr = pend_idx - IDX_W'(1);
        wr_data = rd_data;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_ban <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      filter_ban <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cmd_q       <= cmd_t'(s_tuser);
            addr_q      <= s_tdata;
            mask_q      <= build_mask(s_tdata);
            res_allowed <= 1'b0;
            res_status  <= ST_DONE;
            rd_idx      <= '0;
            pend        <= 1'b0;
            if (cmd_t'(s_tuser) == CMD_NONE) begin
              state <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (hit_now) begin
            pend <= 1'b0;
            case (cmd_q)
              CMD_CHECK: begin
                res_allowed <= !filter_ban;
                state       <= FINISH;
              end
              CMD_REMOVE: begin
                rd_idx <= {1'b0, pend_idx} + CNT_W'(1);
                state  <= SHIFT;
              end
              default: begin
                state <= FINISH;
              end
            endcase
          end else if (rd_en) begin
            rd_idx   <= rd_idx + CNT_W'(1);
            pend     <= 1'b1;
            pend_idx <= rd_addr;
          end else if (!pend) begin
            case (cmd_q)
              CMD_CHECK: begin
                res_allowed <= filter_ban;
              end
              CMD_ADD: begin
                if (count == CNT_W'(DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              CMD_REMOVE: begin
                res_status <= ST_NOT_FOUND;
              end
              default: begin
                res_status <= ST_DONE;
              end
            endcase
            state <= FINISH;
          end else begin
            pend <= 1'b0;
          end
        end
        SHIFT: begin
          if (rd_en) begin
            rd_idx   <= rd_idx + CNT_W'(1);
            pend     <= 1'b1;
            pend_idx <= rd_addr;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - CNT_W'(1);
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_W - 3){1'b0}}, res_status, res_allowed};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ((count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1))))
    else $error("entry count moved by more than one");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ({1'b0, wr_addr} <= count) && ({1'b0, wr_addr} < CNT_W'(DEPTH)))
    else $error("memory write outside the occupied table");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == FINISH))
    else $error("result beat raised outside the finish step");
`endif

endmodule

// ===== sim/masked_ip_filter_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked IP filter table unit testbench
// A short table of directed commands is followed by random check, add, remove
// and unused commands on a small table, then the table is filled to capacity
// to reach the full case. Every result beat is compared with an expected verdict:
// the fixed one of a typed command, else one from a shadow model of the table.
// ----------------------------------------------------------------------------
module masked_ip_filter_table_unit_tb;
  import mift_pkg::*;

  typedef struct packed {
    logic    allowed;
    status_t status;
  } verdict_t;

  typedef enum logic [1:0] {
    ROW_CMD,
    ROW_CMD_TYPED,
    ROW_BAN
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    verdict_t          verdict;
  } row_t;

  localparam verdict_t DONE_VERDICT    = '{1'b0, ST_DONE};
  localparam verdict_t ADMIT_VERDICT   = '{1'b1, ST_DONE};
  localparam verdict_t FULL_VERDICT    = '{1'b0, ST_FULL};
  localparam verdict_t MISSING_VERDICT = '{1'b0, ST_NOT_FOUND};
  localparam int       N_ROWS          = 23;
  localparam int       N_RANDOM        = 560;

  row_t directed_rows [N_ROWS] = '{
    '{ROW_CMD_TYPED, CMD_CHECK,  32'h0000_0000, ADMIT_VERDICT},
    '{ROW_CMD_TYPED, CMD_CHECK,  32'hFFFF_FFFF, ADMIT_VERDICT},
    '{ROW_CMD_TYPED, CMD_REMOVE, 32'h0A00_0001, MISSING_VERDICT},
    '{ROW_CMD_TYPED, CMD_NONE,   32'h1234_5678, DONE_VERDICT},
    '{ROW_CMD_TYPED, CMD_ADD,    32'h0000_A8C0, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'h1234_A8C0, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'h1234_A9C0, DONE_VERDICT},
    '{ROW_CMD,       CMD_ADD,    32'hFFFF_FFFF, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'hFFFF_FFFF, DONE_VERDICT},
    '{ROW_CMD,       CMD_ADD,    32'h0403_0201, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'hFFFF_FFFF, DONE_VERDICT},
    '{ROW_CMD,       CMD_ADD,    32'h0000_0000, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'hDEAD_BEEF, DONE_VERDICT},
    '{ROW_CMD,       CMD_REMOVE, 32'h0000_A8C0, DONE_VERDICT},
    '{ROW_CMD,       CMD_REMOVE, 32'h0000_A8C0, DONE_VERDICT},
    '{ROW_CMD_TYPED, CMD_NONE,   32'hFFFF_FFFF, DONE_VERDICT},
    '{ROW_BAN,       CMD_NONE,   32'h0000_0000, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'h0102_0304, DONE_VERDICT},
    '{ROW_CMD,       CMD_REMOVE, 32'h0000_0000, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'h0102_0304, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'h0403_0201, DONE_VERDICT},
    '{ROW_CMD,       CMD_CHECK,  32'h00FF_00FF, DONE_VERDICT},
    '{ROW_BAN,       CMD_NONE,   32'h0000_0001, DONE_VERDICT}
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [ADDR_W-1:0] s_tdata   = '0;   // address[31:0]
  logic [1:0]        s_tuser   = '0;   // cmd[1:0]
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;          // allowed[0], status[2:1], zero[7:3]
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data  = 1'b0;
  logic              quiet     = 1'b0;

  logic [ADDR_W-1:0] shadow_mask [DEPTH];
  logic [ADDR_W-1:0] shadow_cmp  [DEPTH];
  int                shadow_count = 0;
  logic              shadow_ban   = 1'b1;
  verdict_t          verdict_q [$];
  int                mismatch_count = 0;

  masked_ip_filter_table_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  function automatic logic [ADDR_W-1:0] octet_mask(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] m;
    for (int k = 0; k < 4; k++) begin
      m[8*k +: 8] = {8{|a[8*k +: 8]}};
    end
    return m;
  endfunction

  function automatic int first_free();
    int i;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_cmp[i] == FREE_MARK) break;
    end
    return i;
  endfunction

  function automatic verdict_t filter_predict(input cmd_t c, input logic [ADDR_W-1:0] a);
    verdict_t          v;
    int                slot;
    logic              hit;
    logic [ADDR_W-1:0] m;
    v    = DONE_VERDICT;
    hit  = 1'b0;
    slot = -1;
    m    = octet_mask(a);
    case (c)
      CMD_CHECK: begin
        for (int i = 0; i < shadow_count; i++) begin
          if ((a & shadow_mask[i]) == shadow_cmp[i]) begin
            hit = 1'b1;
            break;
          end
        end
        v.allowed = shadow_ban ? !hit : hit;
      end
      CMD_ADD: begin
        slot = first_free();
        if (slot == shadow_count && shadow_count == DEPTH) begin
          v.status = ST_FULL;
        end else begin
          if (slot == shadow_count) shadow_count++;
          shadow_mask[slot] = m;
          shadow_cmp[slot]  = a;
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_mask[i] == m && shadow_cmp[i] == a) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          v.status = ST_NOT_FOUND;
        end else begin
          for (int j = slot + 1; j < shadow_count; j++) begin
            shadow_mask[j-1] = shadow_mask[j];
            shadow_cmp[j-1]  = shadow_cmp[j];
          end
          shadow_count--;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [ADDR_W-1:0] a;
    int                r;
    if ($urandom_range(0, 3) == 0) return $urandom;
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(0, 9);
      a[8*k +: 8] = (r < 2) ? 8'h00 : (r == 2) ? 8'hFF : 8'($urandom);
    end
    return a;
  endfunction

  task automatic send_command(input cmd_t c, input logic [ADDR_W-1:0] a,
                              input logic typed, input verdict_t typed_v);
    verdict_t v;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= a;
    do @(posedge clk); while (!s_tready);
    v = filter_predict(c, a);
    verdict_q.push_back(typed ? typed_v : v);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic set_ban(input logic v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow_ban = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_command();
    int                r;
    int                pick;
    logic [ADDR_W-1:0] a;
    cmd_t              c;
    r    = $urandom_range(0, 99);
    pick = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
    a    = rand_addr();
    if (r < 40) begin
      c = CMD_CHECK;
      // Fill the wildcard octets of a stored filter so the check hits it.
      if (shadow_count > 0 && r < 22) a = shadow_cmp[pick] | ($urandom & ~shadow_mask[pick]);
    end else if (r < 65 && shadow_count < 40) begin
      c = CMD_ADD;
      if (r < 44) a = FREE_MARK;
      else if (r < 48 && shadow_count > 0) a = shadow_cmp[pick];
    end else if (r < 95) begin
      c = CMD_REMOVE;
      if (shadow_count > 0 && r < 88) a = shadow_cmp[pick];
    end else begin
      c = CMD_NONE;
    end
    send_command(c, a, 1'b0, DONE_VERDICT);
  endtask

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got allowed=%0d status=%0d",
                 $time, m_tdata[0], m_tdata[2:1]);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.allowed || m_tdata[2:1] !== want.status) begin
          $display("%0t: result mismatch, expected allowed=%0d status=%0d, got allowed=%0d status=%0d",
                   $time, want.allowed, want.status, m_tdata[0], m_tdata[2:1]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] a;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_BAN:       set_ban(directed_rows[i].addr[0]);
        ROW_CMD_TYPED: send_command(directed_rows[i].cmd, directed_rows[i].addr, 1'b1,
                                    directed_rows[i].verdict);
        default:       send_command(directed_rows[i].cmd, directed_rows[i].addr, 1'b0,
                                    DONE_VERDICT);
      endcase
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 110 == 0) set_ban(1'($urandom_range(0, 1)));
      quiet <= (n >= 200 && n < 320);
      random_command();
    end

    // Fill every slot so that the table reports full.
    set_ban(1'b1);
    while (!(shadow_count == DEPTH && first_free() == DEPTH)) begin
      do a = rand_addr(); while (a == FREE_MARK);
      send_command(CMD_ADD, a, 1'b0, DONE_VERDICT);
    end
    send_command(CMD_ADD, rand_addr(), 1'b1, FULL_VERDICT);
    send_command(CMD_ADD, FREE_MARK, 1'b1, FULL_VERDICT);
    send_command(CMD_CHECK, shadow_cmp[DEPTH-1], 1'b0, DONE_VERDICT);
    send_command(CMD_CHECK, rand_addr(), 1'b0, DONE_VERDICT);
    set_ban(1'b0);
    send_command(CMD_CHECK, shadow_cmp[DEPTH-1], 1'b0, DONE_VERDICT);
    send_command(CMD_CHECK, rand_addr(), 1'b0, DONE_VERDICT);
    send_command(CMD_REMOVE, shadow_cmp[DEPTH-1], 1'b0, DONE_VERDICT);
    send_command(CMD_ADD, FREE_MARK, 1'b0, DONE_VERDICT);
    send_command(CMD_ADD, rand_addr(), 1'b0, DONE_VERDICT);
    send_command(CMD_ADD, rand_addr(), 1'b0, DONE_VERDICT);
    send_command(CMD_REMOVE, shadow_cmp[0], 1'b0, DONE_VERDICT);

    drain_results();
    repeat (2 * DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mift_pkg.sv
design/masked_ip_filter_table_unit.sv
sim/masked_ip_filter_table_unit_tb.sv
